// File: hdl/bde_pkg.sv
`timescale 1ns / 1ps

package bde_pkg;

   localparam int VALUE_BITS     = 27;
   localparam int SHIFT_BITS     = 5;
   localparam int COUNT_BITS     = 4;
   localparam int CODE_BITS      = 4;
   localparam int NIBBLE_BITS    = 4;
   localparam int BCD_DIGITS     = 8;
   localparam int WORD_BITS      = BCD_DIGITS * NIBBLE_BITS;
   localparam int TOP_NIBBLE_POS = WORD_BITS - NIBBLE_BITS;

   localparam logic [VALUE_BITS-1:0]  BCD_MAX_VALUE = 27'd99999999;
   localparam logic [CODE_BITS-1:0]   BLANK_CODE    = 4'd10;
   localparam logic [NIBBLE_BITS-1:0] DABBLE_LIMIT  = 4'd5;
   localparam logic [NIBBLE_BITS-1:0] DABBLE_ADJUST = 4'd3;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [SHIFT_BITS-1:0] shift_bits;
      logic [COUNT_BITS-1:0] digit_count;
      logic                  blank_leading;
   } req_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] digit_code;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  bcd;
      logic [VALUE_BITS-1:0] bin;
      logic [SHIFT_BITS-1:0] shift_bits;
      logic [COUNT_BITS-1:0] digit_count;
      logic                  blank_leading;
   } conv_type;

endpackage

// File: hdl/bde_dabble_stage.sv
`timescale 1ns / 1ps

module bde_dabble_stage
   import bde_pkg::*;
#(
   parameter int STEPS = 7
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  conv_type up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output conv_type dn_data
);

   logic     valid_ff;
   conv_type stage_ff;
   conv_type stage_in;

   always_comb begin
      logic [WORD_BITS-1:0]  bcd;
      logic [VALUE_BITS-1:0] bin;
      bcd = up_data.bcd;
      bin = up_data.bin;
      for (int s = 0; s < STEPS; s++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd[d*NIBBLE_BITS +: NIBBLE_BITS] >= DABBLE_LIMIT) begin
               bcd[d*NIBBLE_BITS +: NIBBLE_BITS] =
                  bcd[d*NIBBLE_BITS +: NIBBLE_BITS] + DABBLE_ADJUST;
            end
         end
         {bcd, bin} = {bcd[WORD_BITS-2:0], bin, 1'b0};
      end
      stage_in     = up_data;
      stage_in.bcd = bcd;
      stage_in.bin = bin;
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: hdl/bde_serializer.sv
`timescale 1ns / 1ps

module bde_serializer
   import bde_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  conv_type up_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic                   busy_ff;
   logic [WORD_BITS-1:0]   word_ff;
   logic [COUNT_BITS-1:0]  remain_ff;
   logic                   blank_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic                   advance;
   logic                   finishing;
   logic                   load;
   logic [NIBBLE_BITS-1:0] nibble;
   logic                   nibble_zero;
   rsp_type                rsp_in;

   assign advance     = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign finishing   = advance && (remain_ff == COUNT_BITS'(1));
   assign up_ready    = !busy_ff || finishing;
   assign load        = up_valid && up_ready;
   assign nibble      = word_ff[TOP_NIBBLE_POS +: NIBBLE_BITS];
   assign nibble_zero = (nibble == '0);

   always_comb begin
      rsp_in.digit_code = (blank_ff && nibble_zero) ? BLANK_CODE : nibble;
      rsp_in.last       = (remain_ff == COUNT_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            busy_ff <= (up_data.digit_count != '0);
         end else if (advance) begin
            busy_ff <= !finishing;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
      if (load) begin
         word_ff   <= up_data.bcd << up_data.shift_bits;
         remain_ff <= up_data.digit_count;
         blank_ff  <= up_data.blank_leading;
      end else if (advance) begin
         word_ff   <= {word_ff[WORD_BITS-NIBBLE_BITS-1:0], {NIBBLE_BITS{1'b0}}};
         remain_ff <= remain_ff - COUNT_BITS'(1);
         blank_ff  <= blank_ff && nibble_zero;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_busy_has_digits : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (remain_ff != '0))
      else $error("serializer busy with no digits left");

   a_load_only_at_end : assert property (@(posedge clock) disable iff (reset)
      (up_valid && up_ready && busy_ff) |-> finishing)
      else $error("new item loaded over a running digit run");

   a_last_on_final : assert property (@(posedge clock) disable iff (reset)
      finishing |=> (rsp_valid_ff && rsp_data_ff.last))
      else $error("final digit not flagged last");

   a_not_last_mid_run : assert property (@(posedge clock) disable iff (reset)
      (advance && !finishing) |=> (busy_ff && rsp_valid_ff && !rsp_data_ff.last))
      else $error("digit flagged last before end of run");

endmodule

// File: hdl/bcd_digit_emitter.sv
`timescale 1ns / 1ps
// Channel   Ports                            Payload
// request   req_valid / req_ready / req_data  req_type: value, shift_bits, digit_count, blank
// response  rsp_valid / rsp_ready / rsp_data  rsp_type: digit_code, last
//
// Six register stages: input clamp, four binary-to-BCD stages (7, 7, 7, 6 shift-add
// steps), then the digit serializer, which emits one digit per cycle while rsp_ready
// does not stall it. An item occupies the serializer for digit_count digits (clamped to
// MAX_DIGITS); with digit_count zero it emits none. The next item loads with the final digit.
// Synchronous active-high reset clears all valid and busy flags; no clearing pass.
// A stall on rsp_ready backs up through every stage without loss or repetition.

module bcd_digit_emitter
   import bde_pkg::*;
#(
   parameter int MAX_DIGITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int                    COUNT_MAX = (1 << COUNT_BITS) - 1;
   localparam logic [COUNT_BITS-1:0] COUNT_CAP =
      (MAX_DIGITS > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(MAX_DIGITS);
   localparam int                    STAGES    = 4;

   logic     s0_valid_ff;
   conv_type s0_ff;
   conv_type s0_in;

   logic     st_valid [STAGES+1];
   logic     st_ready [STAGES+1];
   conv_type st_data  [STAGES+1];

   always_comb begin
      s0_in.bcd           = '0;
      s0_in.bin           = (req_data.value > BCD_MAX_VALUE) ? BCD_MAX_VALUE
                                                              : req_data.value;
      s0_in.shift_bits    = req_data.shift_bits;
      s0_in.digit_count   = (req_data.digit_count > COUNT_CAP) ? COUNT_CAP
                                                                : req_data.digit_count;
      s0_in.blank_leading = req_data.blank_leading;
   end

   assign req_ready = !s0_valid_ff || st_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s0_ff <= s0_in;
      end
   end

   assign st_valid[0] = s0_valid_ff;
   assign st_data[0]  = s0_ff;

   for (genvar g = 0; g < STAGES; g++) begin : g_dabble
      bde_dabble_stage #(
         .STEPS ((g == STAGES - 1) ? VALUE_BITS - 3 * 7 : 7)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (st_valid[g]),
         .up_ready (st_ready[g]),
         .up_data  (st_data[g]),
         .dn_valid (st_valid[g+1]),
         .dn_ready (st_ready[g+1]),
         .dn_data  (st_data[g+1])
      );
   end

   bde_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (st_valid[STAGES]),
      .up_ready  (st_ready[STAGES]),
      .up_data   (st_data[STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/bcd_digit_checker.sv
`timescale 1ns / 1ps

module bcd_digit_checker
   import bde_pkg::*;
#(
   parameter int MAX_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned mismatch_count,
   output int unsigned outstanding
);

   localparam int unsigned DECIMAL_BASE = 10;

   rsp_type     digit_queue[$];
   int unsigned digit_transfers;

   task automatic report_mismatch(input string what);
      $display("%0t ns: digit transfer %0d: %s", $time, digit_transfers, what);
      mismatch_count++;
   endtask

   // expand one request into the digit codes it must produce
   task automatic predict_digits(input req_type item);
      logic [VALUE_BITS-1:0]  clamped;
      logic [WORD_BITS-1:0]   bcd_word;
      logic [NIBBLE_BITS-1:0] nib;
      int unsigned            remaining;
      int unsigned            count;
      logic                   blanking;
      rsp_type                digit;
      int                     k;
      clamped   = (item.value > BCD_MAX_VALUE) ? BCD_MAX_VALUE : item.value;
      remaining = 32'(clamped);
      bcd_word  = '0;
      for (k = 0; k < BCD_DIGITS; k++) begin
         bcd_word[k*NIBBLE_BITS +: NIBBLE_BITS] = NIBBLE_BITS'(remaining % DECIMAL_BASE);
         remaining = remaining / DECIMAL_BASE;
      end
      bcd_word = bcd_word << item.shift_bits;
      count    = (item.digit_count > MAX_DIGITS) ? MAX_DIGITS : item.digit_count;
      blanking = item.blank_leading;
      for (k = 0; k < count; k++) begin
         nib              = bcd_word[TOP_NIBBLE_POS +: NIBBLE_BITS];
         digit.digit_code = nib;
         if (blanking) begin
            if (nib != '0) begin
               blanking = 1'b0;
            end else begin
               digit.digit_code = BLANK_CODE;
            end
         end
         digit.last = (k == count - 1);
         digit_queue.push_back(digit);
         bcd_word = bcd_word << NIBBLE_BITS;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (digit_queue.size() == 0) begin
               report_mismatch($sformatf("code %0d, last %0b with nothing expected",
                                         rsp_data.digit_code, rsp_data.last));
            end else begin
               want = digit_queue.pop_front();
               if (rsp_data.digit_code !== want.digit_code)
                  report_mismatch($sformatf("digit_code %0d, expected %0d",
                                            rsp_data.digit_code, want.digit_code));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_data.last, want.last));
            end
            digit_transfers++;
         end
         if (req_valid && req_ready)
            predict_digits(req_data);
      end
      outstanding <= digit_queue.size();
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bde_pkg::*;

   localparam int          MAX_DIGITS   = 8;
   localparam int          RESET_CYCLES = 11;
   localparam int          RANDOM_ITEMS = 286;
   localparam int          QUIET_ITEMS  = 50;
   localparam int          HOLD_START   = 800;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 30;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned VALUE_ALL_ONES = (1 << VALUE_BITS) - 1;
   localparam int unsigned SHIFT_ALL_ONES = (1 << SHIFT_BITS) - 1;
   localparam int unsigned COUNT_ALL_ONES = (1 << COUNT_BITS) - 1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned cycle_count;
   bit          idle_enable = 1'b1;

   bcd_digit_emitter #(
      .MAX_DIGITS(MAX_DIGITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   bcd_digit_checker #(
      .MAX_DIGITS(MAX_DIGITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** bcd_digit_emitter: FAILED **");
         $finish;
      end
   end

   function automatic req_type make_item(input int unsigned value, input int unsigned shift,
                                         input int unsigned count, input bit blank);
      req_type item;
      item.value         = VALUE_BITS'(value);
      item.shift_bits    = SHIFT_BITS'(shift);
      item.digit_count   = COUNT_BITS'(count);
      item.blank_leading = blank;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type     item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         item.value = '0;
      else if (pick < 35)
         item.value = VALUE_BITS'($urandom_range(0, 999));
      else if (pick < 50)
         item.value = VALUE_BITS'($urandom_range(BCD_MAX_VALUE + 1, VALUE_ALL_ONES));
      else
         item.value = VALUE_BITS'($urandom_range(0, BCD_MAX_VALUE));
      pick = $urandom_range(0, 9);
      if (pick < 4)
         item.shift_bits = '0;
      else if (pick < 7)
         item.shift_bits = SHIFT_BITS'($urandom_range(0, BCD_DIGITS - 1) * NIBBLE_BITS);
      else
         item.shift_bits = SHIFT_BITS'($urandom_range(0, SHIFT_ALL_ONES));
      pick = $urandom_range(0, 99);
      if (pick < 5)
         item.digit_count = '0;
      else if (pick < 15)
         item.digit_count = COUNT_BITS'($urandom_range(MAX_DIGITS + 1, COUNT_ALL_ONES));
      else
         item.digit_count = COUNT_BITS'($urandom_range(1, MAX_DIGITS));
      item.blank_leading = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // hold valid until the transfer, return at the accepting edge
   task automatic send_item(input req_type item);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   initial begin : response_sink
      int unsigned cycles_seen;
      bit          long_hold_done;
      cycles_seen    = 0;
      long_hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         if (!long_hold_done && cycles_seen >= HOLD_START) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycles_seen += HOLD_CYCLES;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) begin
               @(posedge clock);
               cycles_seen++;
            end
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
            cycles_seen++;
         end
      end
   end

   initial begin : stimulus
      int n;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_item(make_item(0, 0, 8, 1));
      send_item(make_item(0, 0, 8, 0));
      send_item(make_item(BCD_MAX_VALUE, 0, 8, 0));
      send_item(make_item(VALUE_ALL_ONES, 0, 8, 1));
      send_item(make_item(BCD_MAX_VALUE + 1, 0, 8, 0));
      send_item(make_item(12345678, 0, 8, 1));
      send_item(make_item(1000, 0, 8, 1));
      send_item(make_item(10203, 0, 8, 1));
      send_item(make_item(90000000, 0, 8, 1));
      send_item(make_item(12345678, NIBBLE_BITS, 8, 0));
      send_item(make_item(1, SHIFT_ALL_ONES, 8, 0));
      send_item(make_item(7, TOP_NIBBLE_POS, 2, 1));
      send_item(make_item(BCD_MAX_VALUE, 1, 8, 0));
      send_item(make_item(12345678, 3, 8, 1));
      send_item(make_item(12345678, SHIFT_ALL_ONES, 8, 1));
      send_item(make_item(0, 17, 8, 1));
      send_item(make_item(5, 0, 0, 1));
      send_item(make_item(5, 0, 0, 0));
      send_item(make_item(87654321, 0, COUNT_ALL_ONES, 0));
      send_item(make_item(87654321, 0, MAX_DIGITS + 1, 1));
      send_item(make_item(42, 0, 1, 1));
      send_item(make_item(42, 0, 1, 0));
      send_item(make_item(42, 24, 2, 1));
      send_item(make_item(5, 0, 4, 1));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS)
            idle_enable = 1'b0;
         send_item(random_item());
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** bcd_digit_emitter: PASSED **");
      else
         $display("** bcd_digit_emitter: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
hdl/bde_pkg.sv
hdl/bde_dabble_stage.sv
hdl/bde_serializer.sv
hdl/bcd_digit_emitter.sv
bench/bcd_digit_checker.sv
bench/testbench.sv
